>>> sv/assert_macros.svh
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, suspended while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/opd_pkg.sv
// ----------------------------------------------------------------------------
// opd_pkg
// Types and constants shared by the packet deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package opd_pkg;

  // Widest body length that is accepted, in bits.
  localparam int LENGTH_BITS = 32;
  localparam logic [32:0] LEN_MAX = 33'((64'd1 << LENGTH_BITS) - 64'd1);

  // Length octet boundaries.
  localparam logic [7:0] LEN_TWO_OCTET  = 8'd192;
  localparam logic [7:0] LEN_PARTIAL    = 8'd224;
  localparam logic [7:0] LEN_FIVE_OCTET = 8'd255;

  // Header octet fields.
  localparam logic [7:0] HDR_VALID_BIT = 8'h80;
  localparam logic [7:0] HDR_NEW_BIT   = 8'h40;
  localparam logic [7:0] HDR_OLD_TAG   = 8'h3C;
  localparam logic [7:0] HDR_OLD_LT    = 8'h03;
  localparam logic [7:0] HDR_NEW_TAG   = 8'h3F;
  localparam logic [1:0] OLD_LT_INDET  = 2'd3;

  // Octet classification reported with each result.
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_LENGTH  = 3'd1;
  localparam logic [2:0] KIND_TAG     = 3'd2;
  localparam logic [2:0] KIND_BODY    = 3'd3;
  localparam logic [2:0] KIND_DISCARD = 3'd4;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_HDR   = 3'd1;
  localparam logic [2:0] ERR_TRUNC_LEN = 3'd2;
  localparam logic [2:0] ERR_PARTIAL   = 3'd3;
  localparam logic [2:0] ERR_TRUNC_BDY = 3'd4;
  localparam logic [2:0] ERR_EMPTY_SUB = 3'd5;

  // Parser phases, one-hot.
  typedef enum logic [7:0] {
    PH_START      = 8'b0000_0001,
    PH_OLD_LEN    = 8'b0000_0010,
    PH_NEW_FIRST  = 8'b0000_0100,
    PH_NEW_SECOND = 8'b0000_1000,
    PH_NEW_FIVE   = 8'b0001_0000,
    PH_TAG        = 8'b0010_0000,
    PH_BODY       = 8'b0100_0000,
    PH_DISCARD    = 8'b1000_0000
  } phase_t;

  // Input request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  // Result request.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  byte_kind;
    logic [7:0]  pkt_tag;
    logic [31:0] body_length;
    logic        indeterminate;
    logic        packet_end;
    logic [2:0]  error_code;
  } out_item_t;

  // Classified octet held in the queue between front and back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       sub;
    logic       lt192;
    logic       lt224;
    logic       lt255;
  } q_item_t;

endpackage

`default_nettype wire

>>> sv/opd_front.sv
// ----------------------------------------------------------------------------
// opd_front
// Holds the mode register, accepts input requests and classifies each octet
// for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire opd_pkg::in_item_t in_data,
  output logic                  push,
  output opd_pkg::q_item_t      push_item,
  input  wire logic             q_full
);

  logic mode_r;
  logic mode_nxt;

  // The mode register takes every write request.
  assign cfg_ready = 1'b1;
  assign mode_nxt  = (cfg_valid && cfg_ready) ? cfg_data : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // An octet enters the queue whenever there is room.
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Range flags for the length octet decode, with the mode of this octet.
  always_comb begin
    push_item.data_byte = in_data.data_byte;
    push_item.last      = in_data.last;
    push_item.sub       = mode_r;
    push_item.lt192     = in_data.data_byte < opd_pkg::LEN_TWO_OCTET;
    push_item.lt224     = in_data.data_byte < opd_pkg::LEN_PARTIAL;
    push_item.lt255     = in_data.data_byte < opd_pkg::LEN_FIVE_OCTET;
  end

endmodule

`default_nettype wire

>>> sv/opd_fifo.sv
// ----------------------------------------------------------------------------
// opd_fifo
// Two-entry queue of classified octets between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module opd_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire opd_pkg::q_item_t push_item,
  output logic                  q_full,
  output logic                  q_valid,
  output opd_pkg::q_item_t      q_item,
  input  wire logic             pop
);

  opd_pkg::q_item_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_full  = count_r == 2'd2;
  assign q_valid = count_r != 2'd0;
  assign q_item  = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  `ASSERT_CLK(a_count_range, count_r != 2'd3, "queue fill count out of range")
  `ASSERT_CLK(a_count_track,
    (push && !pop) |=> (count_r == $past(count_r) + 2'd1),
    "queue fill count lost a push")

endmodule

`default_nettype wire

>>> sv/opd_back.sv
// ----------------------------------------------------------------------------
// opd_back
// Header and length parser: takes classified octets from the queue, keeps the
// packet state and registers one result per octet.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module opd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire opd_pkg::q_item_t q_item,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output opd_pkg::out_item_t    out_data
);

  opd_pkg::phase_t    phase_r, phase_nxt;
  logic [2:0]         left_r, left_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic [31:0]        body_r, body_nxt;
  logic [7:0]         tag_r, tag_nxt;
  logic [7:0]         first_r, first_nxt;
  logic               runs_r, runs_nxt;
  logic [2:0]         err_r, err_nxt;
  logic               out_valid_r, out_valid_nxt;
  opd_pkg::out_item_t out_data_r;
  opd_pkg::out_item_t res;

  logic [7:0]  b;
  logic        lst;
  logic        sub;
  logic [2:0]  kind;
  logic        ind;
  logic [31:0] blen;
  logic [2:0]  err;
  logic        pend;
  logic        cl_go;
  logic [32:0] cl_len;
  logic [31:0] acc_shift;
  logic [2:0]  left_dec;
  logic [7:0]  hi_part;

  // An octet leaves the queue when the output register is free or emptying.
  assign pop = q_valid && (!out_valid_r || out_ready);

  assign b         = q_item.data_byte;
  assign lst       = q_item.last;
  assign sub       = q_item.sub;
  assign acc_shift = {acc_r[23:0], b};
  assign left_dec  = left_r - 3'd1;
  assign hi_part   = first_r - opd_pkg::LEN_TWO_OCTET;

  // Next state and result for the octet at the head of the queue.
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    acc_nxt   = acc_r;
    body_nxt  = body_r;
    tag_nxt   = tag_r;
    first_nxt = first_r;
    runs_nxt  = runs_r;
    err_nxt   = err_r;
    kind      = opd_pkg::KIND_BODY;
    ind       = 1'b0;
    blen      = 32'd0;
    err       = opd_pkg::ERR_NONE;
    pend      = 1'b0;
    cl_go     = 1'b0;
    cl_len    = 33'd0;

    unique case (phase_r)
      opd_pkg::PH_START, opd_pkg::PH_NEW_FIRST: begin
        if (phase_r == opd_pkg::PH_START && !sub) begin
          // Header octet.
          kind = opd_pkg::KIND_HEADER;
          if (lst) begin
            err = opd_pkg::ERR_TRUNC_LEN;
          end else if ((b & opd_pkg::HDR_VALID_BIT) == 8'd0) begin
            err = opd_pkg::ERR_BAD_HDR;
          end else if ((b & opd_pkg::HDR_NEW_BIT) == 8'd0) begin
            tag_nxt = (b & opd_pkg::HDR_OLD_TAG) >> 2;
            if (b[1:0] == opd_pkg::OLD_LT_INDET) begin
              runs_nxt  = 1'b1;
              ind       = 1'b1;
              phase_nxt = opd_pkg::PH_BODY;
            end else begin
              left_nxt  = 3'(4'd1 << b[1:0]);
              acc_nxt   = 32'd0;
              phase_nxt = opd_pkg::PH_OLD_LEN;
            end
          end else begin
            tag_nxt   = b & opd_pkg::HDR_NEW_TAG;
            phase_nxt = opd_pkg::PH_NEW_FIRST;
          end
        end else begin
          // First new-format length octet.
          kind      = opd_pkg::KIND_LENGTH;
          first_nxt = b;
          if (phase_r == opd_pkg::PH_START) begin
            tag_nxt = 8'd0;
          end
          if (q_item.lt192) begin
            cl_go  = 1'b1;
            cl_len = {25'd0, b};
          end else if (q_item.lt224 || (sub && q_item.lt255)) begin
            if (lst) begin
              err = opd_pkg::ERR_TRUNC_LEN;
            end else begin
              phase_nxt = opd_pkg::PH_NEW_SECOND;
            end
          end else if (q_item.lt255) begin
            err = opd_pkg::ERR_PARTIAL;
          end else if (lst) begin
            err = opd_pkg::ERR_TRUNC_LEN;
          end else begin
            left_nxt  = 3'd4;
            acc_nxt   = 32'd0;
            phase_nxt = opd_pkg::PH_NEW_FIVE;
          end
        end
      end
      opd_pkg::PH_NEW_SECOND: begin
        kind   = opd_pkg::KIND_LENGTH;
        cl_go  = 1'b1;
        cl_len = {17'd0, hi_part, 8'd0} + {25'd0, b} + 33'(opd_pkg::LEN_TWO_OCTET);
      end
      opd_pkg::PH_OLD_LEN, opd_pkg::PH_NEW_FIVE: begin
        kind     = opd_pkg::KIND_LENGTH;
        acc_nxt  = acc_shift;
        left_nxt = left_dec;
        if (left_dec == 3'd0) begin
          cl_go  = 1'b1;
          cl_len = {1'b0, acc_shift};
        end else if (lst) begin
          err = opd_pkg::ERR_TRUNC_LEN;
        end
      end
      opd_pkg::PH_TAG, opd_pkg::PH_BODY: begin
        kind = (phase_r == opd_pkg::PH_TAG) ? opd_pkg::KIND_TAG : opd_pkg::KIND_BODY;
        if (phase_r == opd_pkg::PH_TAG) begin
          tag_nxt = b;
        end
        if (phase_r == opd_pkg::PH_BODY && runs_r) begin
          ind  = 1'b1;
          pend = lst;
        end else begin
          blen     = acc_r;
          body_nxt = body_r - 32'd1;
          if (body_r == 32'd1) begin
            pend      = 1'b1;
            phase_nxt = opd_pkg::PH_START;
          end else if (lst) begin
            err = opd_pkg::ERR_TRUNC_BDY;
          end
        end
      end
      default: begin
        kind = opd_pkg::KIND_DISCARD;
        err  = err_r;
      end
    endcase

    // Completion of a decoded length.
    if (cl_go) begin
      if (cl_len > opd_pkg::LEN_MAX) begin
        err = opd_pkg::ERR_TRUNC_BDY;
      end else begin
        acc_nxt = cl_len[31:0];
        blen    = cl_len[31:0];
        if (cl_len == 33'd0) begin
          if (sub) begin
            err = opd_pkg::ERR_EMPTY_SUB;
          end else begin
            pend      = 1'b1;
            phase_nxt = opd_pkg::PH_START;
          end
        end else begin
          body_nxt  = cl_len[31:0];
          phase_nxt = sub ? opd_pkg::PH_TAG : opd_pkg::PH_BODY;
          if (lst) begin
            err = opd_pkg::ERR_TRUNC_BDY;
          end
        end
      end
    end

    // A fresh or repeated error latches and discards the rest of the data.
    if (err != opd_pkg::ERR_NONE) begin
      err_nxt   = err;
      phase_nxt = opd_pkg::PH_DISCARD;
      pend      = 1'b0;
      ind       = 1'b0;
      if (kind == opd_pkg::KIND_DISCARD) begin
        blen = 32'd0;
      end
    end

    res.out_byte      = b;
    res.byte_kind     = kind;
    res.pkt_tag       = tag_nxt;
    res.body_length   = blen;
    res.indeterminate = ind;
    res.packet_end    = pend;
    res.error_code    = err;

    // The final octet of the data returns the parser to its reset state.
    if (lst) begin
      phase_nxt = opd_pkg::PH_START;
      left_nxt  = 3'd0;
      acc_nxt   = 32'd0;
      body_nxt  = 32'd0;
      tag_nxt   = 8'd0;
      first_nxt = 8'd0;
      runs_nxt  = 1'b0;
      err_nxt   = opd_pkg::ERR_NONE;
    end
  end

  // Parser state advances only on a popped octet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= opd_pkg::PH_START;
      left_r  <= 3'd0;
      acc_r   <= 32'd0;
      body_r  <= 32'd0;
      tag_r   <= 8'd0;
      first_r <= 8'd0;
      runs_r  <= 1'b0;
      err_r   <= opd_pkg::ERR_NONE;
    end else if (pop) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      acc_r   <= acc_nxt;
      body_r  <= body_nxt;
      tag_r   <= tag_nxt;
      first_r <= first_nxt;
      runs_r  <= runs_nxt;
      err_r   <= err_nxt;
    end
  end

  // Output register.
  assign out_valid_nxt = pop || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_CLK(a_err_no_end,
    (out_valid_r && out_data_r.error_code != opd_pkg::ERR_NONE)
      |-> (!out_data_r.packet_end && !out_data_r.indeterminate),
    "error result flags a packet end")
  `ASSERT_CLK(a_last_clears,
    (pop && q_item.last) |=> (phase_r == opd_pkg::PH_START && err_r == opd_pkg::ERR_NONE),
    "final octet did not clear the parser")
  `ASSERT_CLK(a_discard_err,
    (phase_r == opd_pkg::PH_DISCARD) |-> (err_r != opd_pkg::ERR_NONE),
    "discarding without a latched error")

endmodule

`default_nettype wire

>>> sv/openpgp_packet_deframer.sv
// ----------------------------------------------------------------------------
// openpgp_packet_deframer
// Classifies an OpenPGP octet stream into headers, length octets, subpacket
// tags and body octets, one octet per cycle while the receiver takes
// results. An accepted octet enters a two-entry queue, and the parser moves
// it from the head of the queue into the output register, where its result
// waits to be taken. While a result waits to be taken the queue absorbs two
// more octets, after which in_ready falls until the result leaves. The mode
// register (packet or signature subpacket parsing) is to be written while
// idle; an octet marked last returns all parser state to reset and keeps
// the mode.
// ----------------------------------------------------------------------------
`default_nettype none

module openpgp_packet_deframer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire opd_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output opd_pkg::out_item_t     out_data
);

  logic             push;
  opd_pkg::q_item_t push_item;
  logic             q_full;
  logic             q_valid;
  opd_pkg::q_item_t q_item;
  logic             pop;

  // Front: mode register, input handshake and octet classification.
  opd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  // Queue between front and back.
  opd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  // Back: parser and output register.
  opd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the OpenPGP packet deframer. A directed table walks
// through the header forms, the length encodings and every error, then
// random octet streams are sent. Most streams are well-formed packets or
// subpackets with random content; the rest are noise and broken streams.
// Each result is checked field by field against its typed-in value or a
// behavioural model; both sides idle and stall at random in most streams.
// ----------------------------------------------------------------------------
module tb;
  import opd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = 8;
  localparam int SEGMENT_OCTETS = 170;

  // One queued input request, with its expected result where it is typed in.
  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } octet_t;

  // One row of the directed table.
  typedef struct {
    logic       mode;
    logic [7:0] octet;
    logic       last;
    bit         typed;
    out_item_t  want;
  } row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Requests waiting to be sent, and the one on the input port.
  octet_t    octet_q[$];
  octet_t    octet_now;
  // Deframed results still to come, oldest first.
  out_item_t pending_results[$];

  int unsigned octets_queued   = 0;
  int unsigned octets_taken    = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count  = 0;
  int unsigned stuck_cycles    = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_requests   = 0;
  int unsigned recv_hold_seen  = 0;
  int unsigned recv_hold_left  = 0;
  bit          in_fire_d       = 1'b0;
  bit          cfg_fire_d      = 1'b0;
  bit          failed          = 1'b0;
  logic        mode_now        = 1'b0;

  // Model state of the deframer.
  logic        pr_mode;
  phase_t      pr_phase;
  logic [2:0]  pr_len_left;
  logic [31:0] pr_len_acc;
  logic [31:0] pr_body_left;
  logic [7:0]  pr_tag;
  logic [7:0]  pr_first;
  logic        pr_to_end;
  logic [2:0]  pr_err_held;
  // Per-octet working values.
  logic [31:0] pr_blen;
  logic [2:0]  pr_err;
  logic        pr_pend;

  // Directed stimulus. Results are typed in only for the obvious rows.
  row_t directed_rows [27] = '{
    // Header without the valid bit, then discarded up to the last octet.
    '{1'b0, 8'h7F, 1'b0, 1'b1, '{8'h7F, KIND_HEADER, 8'h00, 32'd0, 1'b0, 1'b0, ERR_BAD_HDR}},
    '{1'b0, 8'h55, 1'b1, 1'b1, '{8'h55, KIND_DISCARD, 8'h00, 32'd0, 1'b0, 1'b0, ERR_BAD_HDR}},
    // A header as last octet takes precedence over a bad header.
    '{1'b0, 8'h00, 1'b1, 1'b1, '{8'h00, KIND_HEADER, 8'h00, 32'd0, 1'b0, 1'b0, ERR_TRUNC_LEN}},
    // Old format, one length octet, one body octet.
    '{1'b0, 8'h84, 1'b0, 1'b0, '0},
    '{1'b0, 8'h01, 1'b0, 1'b0, '0},
    '{1'b0, 8'hAA, 1'b0, 1'b0, '0},
    // New format, zero length: ends on the length octet.
    '{1'b0, 8'hC2, 1'b0, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    // Old format of indeterminate length, running to the last octet.
    '{1'b0, 8'h8B, 1'b0, 1'b0, '0},
    '{1'b0, 8'h11, 1'b0, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b1, 1'b0, '0},
    // Two-octet length completed on the last octet: truncated body.
    '{1'b0, 8'hC5, 1'b0, 1'b0, '0},
    '{1'b0, 8'hC0, 1'b0, 1'b0, '0},
    '{1'b0, 8'h00, 1'b1, 1'b1, '{8'h00, KIND_LENGTH, 8'h05, 32'd192, 1'b0, 1'b0, ERR_TRUNC_BDY}},
    // Partial length in packet mode.
    '{1'b0, 8'hC1, 1'b0, 1'b0, '0},
    '{1'b0, 8'hE0, 1'b1, 1'b1, '{8'hE0, KIND_LENGTH, 8'h01, 32'd0, 1'b0, 1'b0, ERR_PARTIAL}},
    // Five-octet length at its largest, completed on the last octet.
    '{1'b0, 8'hC3, 1'b0, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b1, 1'b1,
      '{8'hFF, KIND_LENGTH, 8'h03, 32'hFFFF_FFFF, 1'b0, 1'b0, ERR_TRUNC_BDY}},
    // Subpacket mode: empty subpacket, then data ending inside the length.
    '{1'b1, 8'h00, 1'b1, 1'b1, '{8'h00, KIND_LENGTH, 8'h00, 32'd0, 1'b0, 1'b0, ERR_EMPTY_SUB}},
    '{1'b1, 8'hC0, 1'b1, 1'b1, '{8'hC0, KIND_LENGTH, 8'h00, 32'd0, 1'b0, 1'b0, ERR_TRUNC_LEN}},
    // Subpacket length, then the mode changes before the rest arrives.
    '{1'b1, 8'h02, 1'b0, 1'b0, '0},
    '{1'b0, 8'h21, 1'b0, 1'b0, '0},
    '{1'b0, 8'h33, 1'b1, 1'b0, '0}
  };

  openpgp_packet_deframer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 2 ns clock.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // ------------------------------------------------------------------
  // Deframer model
  // ------------------------------------------------------------------

  function automatic void clear_parser();
    pr_phase     = PH_START;
    pr_len_left  = '0;
    pr_len_acc   = '0;
    pr_body_left = '0;
    pr_tag       = '0;
    pr_first     = '0;
    pr_to_end    = 1'b0;
    pr_err_held  = ERR_NONE;
  endfunction

  // A body length is now known: start the body, or end an empty packet.
  function automatic void close_length(logic [63:0] len, logic lst);
    if (len > 64'(LEN_MAX)) begin
      pr_err = ERR_TRUNC_BDY;
      return;
    end
    pr_len_acc = len[31:0];
    pr_blen    = len[31:0];
    if (len == 64'd0) begin
      if (pr_mode) begin
        pr_err = ERR_EMPTY_SUB;
      end else begin
        pr_pend  = 1'b1;
        pr_phase = PH_START;
      end
    end else begin
      pr_body_left = len[31:0];
      pr_phase     = pr_mode ? PH_TAG : PH_BODY;
      if (lst) pr_err = ERR_TRUNC_BDY;
    end
  endfunction

  // First octet of a new-style length decides its encoding.
  function automatic void open_length(logic [7:0] b, logic lst);
    pr_first = b;
    if (b < LEN_TWO_OCTET) begin
      close_length(64'(b), lst);
    end else if (b < LEN_PARTIAL || (pr_mode && b < LEN_FIVE_OCTET)) begin
      if (lst) pr_err = ERR_TRUNC_LEN;
      else pr_phase = PH_NEW_SECOND;
    end else if (b < LEN_FIVE_OCTET) begin
      pr_err = ERR_PARTIAL;
    end else if (lst) begin
      pr_err = ERR_TRUNC_LEN;
    end else begin
      pr_len_left = 3'd4;
      pr_len_acc  = '0;
      pr_phase    = PH_NEW_FIVE;
    end
  endfunction

  // Classifies one octet and returns the result the deframer should give.
  function automatic out_item_t deframe_octet(in_item_t req);
    out_item_t  res;
    logic [7:0] b;
    logic       lst;
    logic [2:0] kind;
    logic       ind;
    logic [1:0] lt;
    b       = req.data_byte;
    lst     = req.last;
    kind    = KIND_BODY;
    ind     = 1'b0;
    pr_blen = '0;
    pr_err  = ERR_NONE;
    pr_pend = 1'b0;
    case (pr_phase)
      PH_START: begin
        if (pr_mode) begin
          kind   = KIND_LENGTH;
          pr_tag = '0;
          open_length(b, lst);
        end else begin
          kind = KIND_HEADER;
          if (lst) begin
            pr_err = ERR_TRUNC_LEN;
          end else if ((b & HDR_VALID_BIT) == 8'd0) begin
            pr_err = ERR_BAD_HDR;
          end else if ((b & HDR_NEW_BIT) == 8'd0) begin
            lt     = 2'(b & HDR_OLD_LT);
            pr_tag = 8'((b & HDR_OLD_TAG) >> 2);
            if (lt == OLD_LT_INDET) begin
              pr_to_end = 1'b1;
              ind       = 1'b1;
              pr_phase  = PH_BODY;
            end else begin
              pr_len_left = 3'(1 << lt);
              pr_len_acc  = '0;
              pr_phase    = PH_OLD_LEN;
            end
          end else begin
            pr_tag   = b & HDR_NEW_TAG;
            pr_phase = PH_NEW_FIRST;
          end
        end
      end
      PH_NEW_FIRST: begin
        kind = KIND_LENGTH;
        open_length(b, lst);
      end
      PH_NEW_SECOND: begin
        kind = KIND_LENGTH;
        close_length((64'(8'(pr_first - LEN_TWO_OCTET)) << 8) + 64'(b) + 64'(LEN_TWO_OCTET),
                     lst);
      end
      PH_OLD_LEN, PH_NEW_FIVE: begin
        kind        = KIND_LENGTH;
        pr_len_acc  = {pr_len_acc[23:0], b};
        pr_len_left = pr_len_left - 3'd1;
        if (pr_len_left == 3'd0) close_length(64'(pr_len_acc), lst);
        else if (lst) pr_err = ERR_TRUNC_LEN;
      end
      PH_TAG: begin
        kind         = KIND_TAG;
        pr_tag       = b;
        pr_blen      = pr_len_acc;
        pr_body_left = pr_body_left - 32'd1;
        if (pr_body_left == 32'd0) begin
          pr_pend  = 1'b1;
          pr_phase = PH_START;
        end else if (lst) begin
          pr_err = ERR_TRUNC_BDY;
        end
      end
      PH_BODY: begin
        kind = KIND_BODY;
        if (pr_to_end) begin
          ind = 1'b1;
          if (lst) pr_pend = 1'b1;
        end else begin
          pr_blen      = pr_len_acc;
          pr_body_left = pr_body_left - 32'd1;
          if (pr_body_left == 32'd0) begin
            pr_pend  = 1'b1;
            pr_phase = PH_START;
          end else if (lst) begin
            pr_err = ERR_TRUNC_BDY;
          end
        end
      end
      default: begin
        kind   = KIND_DISCARD;
        pr_err = pr_err_held;
      end
    endcase
    // Errors latch and send the parser to discard until the last octet.
    if (pr_err != ERR_NONE) begin
      pr_err_held = pr_err;
      pr_phase    = PH_DISCARD;
      pr_pend     = 1'b0;
      ind         = 1'b0;
      if (kind == KIND_DISCARD) pr_blen = '0;
    end
    res.out_byte      = b;
    res.byte_kind     = kind;
    res.pkt_tag       = pr_tag;
    res.body_length   = pr_blen;
    res.indeterminate = ind;
    res.packet_end    = pr_pend;
    res.error_code    = pr_err;
    if (lst) clear_parser();
    return res;
  endfunction

  function automatic bit field_bad(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) return 1'b0;
    $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    mismatch_count++;
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------
  // Monitor: samples at the rising edge, predicts and checks
  // ------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    bit        bad;
    if (!rst_n) begin
      pr_mode    = 1'b0;
      clear_parser();
      in_fire_d  = 1'b0;
      cfg_fire_d = 1'b0;
    end else begin
      in_fire_d  = in_valid && in_ready;
      cfg_fire_d = cfg_valid && cfg_ready;
      // A result request is checked against the oldest expectation.
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          failed = 1'b1;
          $display("%0t ns: expected no result, got %p", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          bad = field_bad("out_byte", 32'(want.out_byte), 32'(out_data.out_byte))
              | field_bad("byte_kind", 32'(want.byte_kind), 32'(out_data.byte_kind))
              | field_bad("pkt_tag", 32'(want.pkt_tag), 32'(out_data.pkt_tag))
              | field_bad("body_length", want.body_length, out_data.body_length)
              | field_bad("indeterminate", 32'(want.indeterminate),
                          32'(out_data.indeterminate))
              | field_bad("packet_end", 32'(want.packet_end), 32'(out_data.packet_end))
              | field_bad("error_code", 32'(want.error_code), 32'(out_data.error_code));
          if (bad) failed = 1'b1;
        end
      end
      // The model always runs so that its state follows the stream.
      if (in_fire_d) begin
        got = deframe_octet(octet_now.req);
        pending_results.insert(pending_results.size(), octet_now.typed ? octet_now.want : got);
        octets_taken++;
      end
      if (cfg_fire_d) pr_mode = cfg_data;
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Sender: offers the next queued request at the falling edge, idling at random.
  always @(negedge clk) begin
    if (!in_valid || in_fire_d) begin
      if (octet_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        octet_now = octet_q.pop_front();
        in_valid <= 1'b1;
        in_data  <= octet_now.req;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls at random, and holds off for a long stretch when asked.
  always @(negedge clk) begin
    if (recv_hold_seen != hold_requests) begin
      recv_hold_seen = hold_requests;
      recv_hold_left = LONG_HOLD;
    end
    if (recv_hold_left != 0) begin
      recv_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------

  task automatic push_octet(input logic [7:0] b, input logic lst, input bit typed,
                            input out_item_t want);
    octet_t o;
    o.req.data_byte = b;
    o.req.last      = lst;
    o.typed         = typed;
    o.want          = want;
    octet_q.insert(octet_q.size(), o);
    octets_queued++;
  endtask

  // Waits until every queued request has been taken and answered.
  task automatic wait_drained();
    while (octets_taken != octets_queued || results_checked != octets_taken)
      @(negedge clk);
  endtask

  // The mode register is only written while nothing is in flight.
  task automatic write_mode(input logic m);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(negedge clk); while (!cfg_fire_d);
    cfg_valid <= 1'b0;
    mode_now = m;
  endtask

  initial begin : stimulus
    row_t        row;
    logic [7:0]  run[$];
    logic [31:0] len;
    logic [31:0] v;
    logic [1:0]  lt;
    int unsigned target;
    int unsigned n_pk;
    int unsigned corrupt;
    int unsigned keep;
    int          k;
    bit          paused;
    paused = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    write_mode(1'b0);

    // Directed table.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.mode != mode_now) write_mode(row.mode);
      push_octet(row.octet, row.last, row.typed, row.want);
    end

    // Random streams, in four idling patterns and both modes.
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (int m = 0; m < 2; m++) begin
        write_mode(m == 1);
        // Receiver holds off while the sender keeps offering.
        if (seg == 0 && m == 0) hold_requests++;
        target = octets_queued + SEGMENT_OCTETS;
        while (octets_queued < target) begin
          run.delete();
          n_pk = $urandom_range(1, 3);
          for (int p = 0; p < n_pk; p++) begin
            len = ($urandom_range(99) < 2) ? $urandom_range(192, 200) : $urandom_range(0, 8);
            if (!mode_now && $urandom_range(9) < 4) begin
              // Old format; indeterminate length only for the final packet.
              lt = (p == n_pk - 1 && $urandom_range(3) == 0) ? OLD_LT_INDET
                                                              : 2'($urandom_range(2));
              run.insert(run.size(),
                         HDR_VALID_BIT | 8'($urandom_range(15) << 2) | 8'(lt));
              if (lt == OLD_LT_INDET) begin
                len = $urandom_range(0, 6);
              end else begin
                for (k = (1 << lt) - 1; k >= 0; k--) run.insert(run.size(), len[8*k +: 8]);
              end
            end else begin
              // New format header, or none in subpacket mode, then the length.
              if (!mode_now)
                run.insert(run.size(), HDR_VALID_BIT | HDR_NEW_BIT | 8'($urandom_range(63)));
              else if (len == 0) len = 1;
              if (len < 192 && $urandom_range(3) != 0) begin
                run.insert(run.size(), len[7:0]);
              end else if (len >= 192 && $urandom_range(1) == 1) begin
                v = len - 32'd192;
                run.insert(run.size(), 8'(LEN_TWO_OCTET + v[15:8]));
                run.insert(run.size(), v[7:0]);
              end else begin
                run.insert(run.size(), LEN_FIVE_OCTET);
                for (k = 3; k >= 0; k--) run.insert(run.size(), len[8*k +: 8]);
              end
            end
            // In subpacket mode the first of these is the tag.
            repeat (len) run.insert(run.size(), 8'($urandom));
          end

          // Most runs go out intact; the rest are noise or broken.
          corrupt = $urandom_range(99);
          if (corrupt < 6) begin
            repeat ($urandom_range(1, 6))
              push_octet(8'($urandom), 1'($urandom_range(1)), 1'b0, '0);
          end else begin
            if (corrupt < 10) begin
              keep = $urandom_range(1, run.size());
              while (run.size() > keep) run.delete(run.size() - 1);
            end else if (corrupt < 14) begin
              run[$urandom_range(0, run.size() - 1)] = 8'($urandom);
            end else if (corrupt < 20) begin
              // Long, partial or empty lengths followed by a few octets.
              run.delete();
              if (!mode_now)
                run.insert(run.size(), HDR_VALID_BIT | HDR_NEW_BIT | 8'($urandom_range(63)));
              run.insert(run.size(),
                         $urandom_range(1) ? 8'($urandom_range(192, 255)) : 8'd0);
              repeat ($urandom_range(0, 3)) run.insert(run.size(), 8'($urandom));
            end
            foreach (run[i]) push_octet(run[i], i == run.size() - 1, 1'b0, '0);
          end

          // Sender pauses once until every result has come back.
          if (seg == 1 && !paused && octets_queued + SEGMENT_OCTETS / 2 > target) begin
            paused = 1'b1;
            wait_drained();
          end
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (!failed && mismatch_count == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> openpgp_packet_deframer.f
+incdir+sv
sv/opd_pkg.sv
sv/opd_front.sv
sv/opd_fifo.sv
sv/opd_back.sv
sv/openpgp_packet_deframer.sv
tb/tb.sv
